>>> rtl/pip_pkg.sv
// Shared types and constants for the periodic image point block.
// Holds the payload structs, the configuration and side-band structs and the
// fixed-point widths; depends on nothing.
package pip_pkg;

	localparam int POS_FRAC_BITS = 16;
	localparam int RECIP_FRAC_BITS = 30;
	localparam int SHIFT_BITS = 4;

	// Fractional coordinates carry both fraction widths; the integer cell index is what is left.
	localparam int FRAC_SHIFT = POS_FRAC_BITS + RECIP_FRAC_BITS;
	localparam int N_W = 64 - FRAC_SHIFT;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_RECT = 2'd1;
	localparam logic [1:0] MODE_TRIC = 2'd2;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [SHIFT_BITS-1:0] shift_x;
		logic signed [SHIFT_BITS-1:0] shift_y;
		logic signed [SHIFT_BITS-1:0] shift_z;
		logic center_origin;
		logic nearest_image;
	} pt_t;

	typedef struct packed {
		logic signed [31:0] image_x;
		logic signed [31:0] image_y;
		logic signed [31:0] image_z;
	} img_t;

	// Cell and reciprocal entries in the order 00 01 02 11 12 22.
	typedef struct packed {
		logic [1:0] mode;
		logic [5:0][31:0] box;
		logic [5:0][31:0] recip;
	} cfg_t;

	// Per-item data that rides along the pipeline beside the image search.
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][SHIFT_BITS-1:0] k;
		logic o;
		logic near;
		logic [1:0] mode;
		logic [2:0][N_W-1:0] n;
	} side_t;

endpackage

>>> rtl/pip_regs.sv
// Configuration register file on an APB-style port.
// Uses pip_pkg for the configuration struct and the box mode codes.
module pip_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [5:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output pip_pkg::cfg_t cfg
);

	localparam logic [2:0] REG_BOX_MODE = 3'd0;
	localparam logic [2:0] REG_CELL_AB = 3'd1;
	localparam logic [2:0] REG_CELL_BC = 3'd2;
	localparam logic [2:0] REG_CELL_CZ = 3'd3;
	localparam logic [2:0] REG_RECIP_A = 3'd4;
	localparam logic [2:0] REG_RECIP_B = 3'd5;
	localparam logic [2:0] REG_RECIP_C = 3'd6;

	logic [1:0] mode_q;
	logic [5:0][31:0] cell_q;
	logic [5:0][31:0] recip_q;
	logic [2:0] idx;
	logic wr;

	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pip_pkg::MODE_NONE;
			cell_q <= '0;
			recip_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_BOX_MODE: mode_q <= pwdata[1:0];
				REG_CELL_AB: begin
					cell_q[0] <= pwdata[63:32];
					cell_q[1] <= pwdata[31:0];
				end
				REG_CELL_BC: begin
					cell_q[2] <= pwdata[63:32];
					cell_q[3] <= pwdata[31:0];
				end
				REG_CELL_CZ: begin
					cell_q[4] <= pwdata[63:32];
					cell_q[5] <= pwdata[31:0];
				end
				REG_RECIP_A: begin
					recip_q[0] <= pwdata[63:32];
					recip_q[1] <= pwdata[31:0];
				end
				REG_RECIP_B: begin
					recip_q[2] <= pwdata[63:32];
					recip_q[3] <= pwdata[31:0];
				end
				REG_RECIP_C: begin
					recip_q[4] <= pwdata[63:32];
					recip_q[5] <= pwdata[31:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BOX_MODE: prdata = {62'd0, mode_q};
			REG_CELL_AB: prdata = {cell_q[0], cell_q[1]};
			REG_CELL_BC: prdata = {cell_q[2], cell_q[3]};
			REG_CELL_CZ: prdata = {cell_q[4], cell_q[5]};
			REG_RECIP_A: prdata = {recip_q[0], recip_q[1]};
			REG_RECIP_B: prdata = {recip_q[2], recip_q[3]};
			REG_RECIP_C: prdata = {recip_q[4], recip_q[5]};
			default: prdata = '0;
		endcase
	end

	assign cfg.mode = mode_q;
	assign cfg.box = cell_q;
	assign cfg.recip = recip_q;

endmodule

>>> rtl/pip_frac.sv
// Front of the pipeline: input register, reciprocal products and fractional coordinates.
// Uses pip_pkg for payload, configuration and side-band types.
module pip_frac (
	input logic clk,
	input pip_pkg::cfg_t cfg,
	input logic [2:0] en,
	input pip_pkg::pt_t pt,
	output pip_pkg::side_t side,
	output logic [2:0][pip_pkg::POS_FRAC_BITS-1:0] fr
);

	localparam int FS = pip_pkg::FRAC_SHIFT;
	localparam int RF = pip_pkg::RECIP_FRAC_BITS;

	pip_pkg::pt_t pt_s1;
	pip_pkg::pt_t pt_s2;
	logic signed [63:0] prod_s2 [6];
	pip_pkg::side_t side_s3;
	logic [2:0][pip_pkg::POS_FRAC_BITS-1:0] fr_s3;

	logic tric;
	logic signed [63:0] f [3];
	logic signed [63:0] s01;

	function automatic logic signed [63:0] sat65(input logic signed [64:0] x);
		if (x[64] != x[63])
			return {x[64], {63{~x[64]}}};
		return x[63:0];
	endfunction

	assign tric = cfg.mode == pip_pkg::MODE_TRIC;

	always_ff @(posedge clk) begin
		if (en[0])
			pt_s1 <= pt;
		if (en[1]) begin
			pt_s2 <= pt_s1;
			prod_s2[0] <= 64'(pt_s1.pos_x) * 64'($signed(cfg.recip[0]));
			prod_s2[1] <= tric ? 64'(pt_s1.pos_y) * 64'($signed(cfg.recip[1])) : 64'sd0;
			prod_s2[2] <= tric ? 64'(pt_s1.pos_z) * 64'($signed(cfg.recip[2])) : 64'sd0;
			prod_s2[3] <= 64'(pt_s1.pos_y) * 64'($signed(cfg.recip[3]));
			prod_s2[4] <= tric ? 64'(pt_s1.pos_z) * 64'($signed(cfg.recip[4])) : 64'sd0;
			prod_s2[5] <= 64'(pt_s1.pos_z) * 64'($signed(cfg.recip[5]));
		end
	end

	// Each partial sum saturates at the signed 64-bit limits before the next term is added.
	always_comb begin
		s01 = sat65(65'(prod_s2[0]) + 65'(prod_s2[1]));
		f[0] = sat65(65'(s01) + 65'(prod_s2[2]));
		f[1] = sat65(65'(prod_s2[3]) + 65'(prod_s2[4]));
		f[2] = prod_s2[5];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s3.p <= {pt_s2.pos_z, pt_s2.pos_y, pt_s2.pos_x};
			side_s3.k <= {pt_s2.shift_z, pt_s2.shift_y, pt_s2.shift_x};
			side_s3.o <= pt_s2.center_origin;
			side_s3.near <= pt_s2.nearest_image;
			side_s3.mode <= cfg.mode;
			for (int a = 0; a < 3; a++) begin
				side_s3.n[a] <= f[a][63:FS];
				fr_s3[a] <= f[a][FS-1:RF];
			end
		end
	end

	assign side = side_s3;
	assign fr = fr_s3;

endmodule

>>> rtl/pip_near.sv
// Nearest-image search over the 27 neighbor cells, pipelined in eight stages.
// Uses pip_pkg for configuration and side-band types.
module pip_near (
	input logic clk,
	input pip_pkg::cfg_t cfg,
	input logic [7:0] en,
	input pip_pkg::side_t side_i,
	input logic [2:0][pip_pkg::POS_FRAC_BITS-1:0] fr,
	output pip_pkg::side_t side_o,
	output logic [2:0][1:0] mcode
);

	localparam int PF = pip_pkg::POS_FRAC_BITS;
	localparam int DW = PF + 3;
	localparam int PDW = DW + 32;
	localparam int MW = PDW + 2;
	localparam int AW = MW - 32;
	localparam int SQW = 2 * MW;
	localparam int SW = SQW + 2;

	pip_pkg::side_t side_s4, side_s5, side_s6, side_s7, side_s8, side_s9, side_s10, side_s11;

	logic signed [DW-1:0] dv [3][3];
	logic signed [PDW-1:0] pa_s4 [3], pb_s4 [3], pc_s4 [3], qb_s4 [3], qc_s4 [3], rc_s4 [3];
	logic [MW-1:0] mag_s5 [39];
	logic [2*AW-1:0] aa_s6 [39];
	logic [MW-1:0] ab_s6 [39];
	logic [63:0] bb_s6 [39];
	logic [SQW-1:0] sq_s7 [39];
	logic [SW-1:0] dist_s8 [27];
	logic [SW-1:0] d_s9 [9];
	logic [5:0] c_s9 [9];
	logic [SW-1:0] d_s10 [3];
	logic [5:0] c_s10 [3];
	logic [5:0] c_s11;

	logic [MW-1:0] mag_n [39];
	logic [SW-1:0] d9_n [9];
	logic [5:0] c9_n [9];
	logic [SW-1:0] d3_n [3];
	logic [5:0] c3_n [3];
	logic [5:0] c1_n;

	function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] x);
		return x[MW-1] ? MW'(-x) : MW'(x);
	endfunction

	// Doubled offsets from the cell center for image choices -1, 0 and +1.
	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int i = 0; i < 3; i++)
				dv[a][i] = (DW'({1'b0, fr[a]}) <<< 1) + ($signed(DW'(2 * i - 3)) <<< PF);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s4 <= side_i;
			for (int i = 0; i < 3; i++) begin
				pa_s4[i] <= PDW'(dv[0][i]) * PDW'($signed(cfg.box[0]));
				pb_s4[i] <= PDW'(dv[1][i]) * PDW'($signed(cfg.box[1]));
				pc_s4[i] <= PDW'(dv[2][i]) * PDW'($signed(cfg.box[2]));
				qb_s4[i] <= PDW'(dv[1][i]) * PDW'($signed(cfg.box[3]));
				qc_s4[i] <= PDW'(dv[2][i]) * PDW'($signed(cfg.box[4]));
				rc_s4[i] <= PDW'(dv[2][i]) * PDW'($signed(cfg.box[5]));
			end
		end
	end

	// Entries 0..26 are the first cell row, 27..35 the second, 36..38 the third.
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					mag_n[i*9 + j*3 + k] = mag_of(MW'(pa_s4[i]) + MW'(pb_s4[j]) + MW'(pc_s4[k]));
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++)
				mag_n[27 + j*3 + k] = mag_of(MW'(qb_s4[j]) + MW'(qc_s4[k]));
		for (int k = 0; k < 3; k++)
			mag_n[36 + k] = mag_of(MW'(rc_s4[k]));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s5 <= side_s4;
			mag_s5 <= mag_n;
		end
		if (en[2]) begin
			side_s6 <= side_s5;
			for (int e = 0; e < 39; e++) begin
				aa_s6[e] <= (2*AW)'(mag_s5[e][MW-1:32]) * (2*AW)'(mag_s5[e][MW-1:32]);
				ab_s6[e] <= MW'(mag_s5[e][MW-1:32]) * MW'(mag_s5[e][31:0]);
				bb_s6[e] <= 64'(mag_s5[e][31:0]) * 64'(mag_s5[e][31:0]);
			end
		end
		if (en[3]) begin
			side_s7 <= side_s6;
			for (int e = 0; e < 39; e++)
				sq_s7[e] <= (SQW'(aa_s6[e]) << 64) + (SQW'(ab_s6[e]) << 33) + SQW'(bb_s6[e]);
		end
		if (en[4]) begin
			side_s8 <= side_s7;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					for (int k = 0; k < 3; k++)
						dist_s8[i*9 + j*3 + k] <= SW'(sq_s7[i*9 + j*3 + k])
							+ SW'(sq_s7[27 + j*3 + k]) + SW'(sq_s7[36 + k]);
		end
	end

	// Minimum tree in candidate order; a later candidate wins only when strictly closer.
	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				d9_n[i*3 + j] = dist_s8[i*9 + j*3];
				c9_n[i*3 + j] = {2'(i), 2'(j), 2'd0};
				for (int k = 1; k < 3; k++)
					if (dist_s8[i*9 + j*3 + k] < d9_n[i*3 + j]) begin
						d9_n[i*3 + j] = dist_s8[i*9 + j*3 + k];
						c9_n[i*3 + j] = {2'(i), 2'(j), 2'(k)};
					end
			end
		for (int g = 0; g < 3; g++) begin
			d3_n[g] = d_s9[g*3];
			c3_n[g] = c_s9[g*3];
			for (int t = 1; t < 3; t++)
				if (d_s9[g*3 + t] < d3_n[g]) begin
					d3_n[g] = d_s9[g*3 + t];
					c3_n[g] = c_s9[g*3 + t];
				end
		end
		c1_n = c_s10[0];
		if (d_s10[1] < d_s10[0]) begin
			c1_n = c_s10[1];
			if (d_s10[2] < d_s10[1])
				c1_n = c_s10[2];
		end else if (d_s10[2] < d_s10[0]) begin
			c1_n = c_s10[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			side_s9 <= side_s8;
			d_s9 <= d9_n;
			c_s9 <= c9_n;
		end
		if (en[6]) begin
			side_s10 <= side_s9;
			d_s10 <= d3_n;
			c_s10 <= c3_n;
		end
		if (en[7]) begin
			side_s11 <= side_s10;
			c_s11 <= c1_n;
		end
	end

	assign side_o = side_s11;
	assign mcode[0] = c_s11[5:4];
	assign mcode[1] = c_s11[3:2];
	assign mcode[2] = c_s11[1:0];

endmodule

>>> rtl/pip_back.sv
// Back of the pipeline: cell offset products, image position and 32-bit saturation.
// Uses pip_pkg for configuration, side-band and result types.
module pip_back (
	input logic clk,
	input pip_pkg::cfg_t cfg,
	input logic [1:0] en,
	input pip_pkg::side_t side,
	input logic [2:0][1:0] mcode,
	output pip_pkg::img_t img
);

	localparam int HW = pip_pkg::N_W + 3;
	localparam int UW = HW + 32;
	localparam int TW = UW + 4;

	logic signed [UW-1:0] u_s12 [6];
	logic [2:0][31:0] p_s12;
	logic [1:0] mode_s12;
	pip_pkg::img_t img_s13;

	logic tric;
	logic use_near;
	logic signed [2:0] mv [3];
	logic signed [HW-1:0] hs [3];
	logic signed [TW-1:0] t [3];
	logic signed [TW-1:0] r [3];
	logic [2:0][31:0] res;

	function automatic logic [31:0] sat32(input logic signed [TW-1:0] x);
		if (x[TW-1:31] != {(TW-31){x[31]}})
			return x[TW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
		return x[31:0];
	endfunction

	assign tric = side.mode == pip_pkg::MODE_TRIC;
	assign use_near = tric && side.near;

	// Doubled cell multiple: 2n - 2m - 2k plus one when the origin is centered.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mv[a] = use_near ? $signed({1'b0, mcode[a]} - 3'd1) : 3'sd0;
			hs[a] = (HW'($signed(side.n[a])) <<< 1) - (HW'(mv[a]) <<< 1)
				- (HW'($signed(side.k[a])) <<< 1) + HW'(side.o);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s12 <= side.p;
			mode_s12 <= side.mode;
			u_s12[0] <= UW'(hs[0]) * UW'($signed(cfg.box[0]));
			u_s12[1] <= tric ? UW'(hs[1]) * UW'($signed(cfg.box[1])) : '0;
			u_s12[2] <= tric ? UW'(hs[2]) * UW'($signed(cfg.box[2])) : '0;
			u_s12[3] <= UW'(hs[1]) * UW'($signed(cfg.box[3]));
			u_s12[4] <= tric ? UW'(hs[2]) * UW'($signed(cfg.box[4])) : '0;
			u_s12[5] <= UW'(hs[2]) * UW'($signed(cfg.box[5]));
		end
	end

	always_comb begin
		t[0] = TW'(u_s12[0]) + TW'(u_s12[1]) + TW'(u_s12[2]);
		t[1] = TW'(u_s12[3]) + TW'(u_s12[4]);
		t[2] = TW'(u_s12[5]);
		for (int a = 0; a < 3; a++) begin
			r[a] = ((TW'($signed(p_s12[a])) <<< 1) - t[a]) >>> 1;
			if (mode_s12 == pip_pkg::MODE_RECT || mode_s12 == pip_pkg::MODE_TRIC)
				res[a] = sat32(r[a]);
			else
				res[a] = p_s12[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			img_s13.image_x <= res[0];
			img_s13.image_y <= res[1];
			img_s13.image_z <= res[2];
		end
	end

	assign img = img_s13;

endmodule

>>> rtl/periodic_image_point.sv
// Top level of the periodic image point block: pipeline control and the three stage groups.
// Depends on pip_pkg, pip_regs, pip_frac, pip_near and pip_back.
//
//   channel  direction  handshake               payload
//   pt       in         pt_valid / pt_ready     pt_data  (pip_pkg::pt_t)
//   img      out        img_valid / img_ready   img_data (pip_pkg::img_t)
//   apb      in         psel, penable, pready   paddr, pwdata, prdata (64 bits)
//
// One item per cycle unless a full pipeline waits on img_ready.
// Most of the stages belong to the nearest-image search: split squarers and a three-level minimum tree.
// Every stage has a valid bit and advances when it is empty or the stage after it advances,
// so bubbles close up and input is still taken while a result waits at the output, as long as some stage is empty.
// Reset clears the valid bits and the configuration registers.
module periodic_image_point (
	input logic clk,
	input logic arst_n,
	input logic pt_valid,
	output logic pt_ready,
	input pip_pkg::pt_t pt_data,
	output logic img_valid,
	input logic img_ready,
	output pip_pkg::img_t img_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [5:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	localparam int NUM_STAGES = 13;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	pip_pkg::cfg_t cfg;
	pip_pkg::side_t side_f;
	pip_pkg::side_t side_n;
	logic [2:0][pip_pkg::POS_FRAC_BITS-1:0] fr;
	logic [2:0][1:0] mcode;

	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || img_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= pt_valid;
			for (int i = 1; i < NUM_STAGES; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign pt_ready = en[0];
	assign img_valid = vld_q[NUM_STAGES-1];

	pip_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	pip_frac u_frac (
		.clk(clk),
		.cfg(cfg),
		.en(en[2:0]),
		.pt(pt_data),
		.side(side_f),
		.fr(fr)
	);

	pip_near u_near (
		.clk(clk),
		.cfg(cfg),
		.en(en[10:3]),
		.side_i(side_f),
		.fr(fr),
		.side_o(side_n),
		.mcode(mcode)
	);

	pip_back u_back (
		.clk(clk),
		.cfg(cfg),
		.en(en[12:11]),
		.side(side_n),
		.mcode(mcode),
		.img(img_data)
	);

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && pt_ready) |=> vld_q[0])
		else $error("accepted item did not enter the first stage");

	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		img_ready |-> pt_ready)
		else $error("input stalled while the output drains");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pt_ready |-> ((&vld_q) && !img_ready))
		else $error("input stalled with a bubble in the pipeline");

	a_search_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[10] |-> (mcode[0] != 2'd3 && mcode[1] != 2'd3 && mcode[2] != 2'd3))
		else $error("nearest image code out of range");

endmodule
